// ----- design/twcw_pkg.sv -----
package twcw_pkg;

  // Character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] LOW7_MASK  = 8'h7F;
  localparam logic [7:0] PRINT_MIN  = 8'd32;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

  // Flags of one row sweep job
  typedef struct packed {
    logic src_valid;
    logic dst_valid;
    logic has_char;
  } row_job_flags_t;

  // Status of the row sweep engine
  typedef struct packed {
    logic active;
    logic busy;
    logic done;
  } row_eng_status_t;

  // Index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- design/twcw_ram.sv -----
module twcw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/twcw_row_engine.sv -----
module twcw_row_engine import twcw_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  row_job_flags_t                      flags,
  input  logic [idx_w(MAX_ROWS)-1:0]          dst_row,
  input  logic [idx_w(MAX_ROWS)-1:0]          src_row,
  input  logic [idx_w(MAX_COLS)-1:0]          char_col,
  input  logic [7:0]                          char_val,
  input  logic [$clog2(MAX_COLS+1)-1:0]       cols,
  output row_eng_status_t                     status,
  output logic                                rd_en,
  output logic [idx_w(MAX_ROWS)+idx_w(MAX_COLS)-1:0] rd_addr,
  input  logic [7:0]                          rd_data,
  output logic                                wr_en,
  output logic [idx_w(MAX_ROWS)+idx_w(MAX_COLS)-1:0] wr_addr,
  output logic [7:0]                          wr_data
);

  localparam int RW  = idx_w(MAX_ROWS);
  localparam int CW  = idx_w(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);

  typedef enum logic [1:0] {
    WK_NONE  = 2'd0,
    WK_CHAR  = 2'd1,
    WK_COPY  = 2'd2,
    WK_SPACE = 2'd3
  } wr_kind_t;

  logic                 active;
  logic [CW-1:0]        col;
  row_job_flags_t       j_flags;
  logic [RW-1:0]        j_dst;
  logic [RW-1:0]        j_src;
  logic [CW-1:0]        j_char_col;
  logic [7:0]           j_char;
  logic [CNW-1:0]       j_cols;

  logic                 s1_valid;
  logic                 s1_last;
  wr_kind_t             s1_kind;
  logic [RW+CW-1:0]     s1_addr;
  logic [7:0]           s1_char;

  wr_kind_t             kind;

  // Decide what goes into the destination cell while its source is read
  always_comb begin
    if (j_flags.has_char && col == j_char_col) begin
      kind = WK_CHAR;
    end else if ({1'b0, col} < (CW+1)'(j_cols)) begin
      kind = j_flags.src_valid ? WK_COPY : WK_SPACE;
    end else if (j_flags.dst_valid) begin
      kind = WK_NONE;
    end else begin
      kind = WK_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= active;
      s1_last  <= active && col == LAST_COL;
      if (start) begin
        active <= 1'b1;
      end else if (active && col == LAST_COL) begin
        active <= 1'b0;
      end
    end
    if (start) begin
      col        <= '0;
      j_flags    <= flags;
      j_dst      <= dst_row;
      j_src      <= src_row;
      j_char_col <= char_col;
      j_char     <= char_val;
      j_cols     <= cols;
    end else if (active) begin
      col <= col + 1'b1;
    end
    if (active) begin
      s1_kind <= kind;
      s1_addr <= {j_dst, col};
      s1_char <= j_char;
    end
  end

  assign rd_en   = active && j_flags.src_valid;
  assign rd_addr = {j_src, col};

  assign wr_en   = s1_valid && s1_kind != WK_NONE;
  assign wr_addr = s1_addr;

  always_comb begin
    unique case (s1_kind)
      WK_CHAR:  wr_data = s1_char;
      WK_COPY:  wr_data = rd_data;
      WK_SPACE: wr_data = CHAR_SPACE;
      WK_NONE:  wr_data = CHAR_SPACE;
    endcase
  end

  assign status.active = active;
  assign status.busy   = active || s1_valid;
  assign status.done   = s1_valid && s1_last;

endmodule

// ----- design/text_window_char_writer.sv -----
// Character-cell text window with cursor, line wrap and scroll.
//
// Input stream (s_*): one transaction per item. s_tuser carries the command
// (write character, clear, read cell, acknowledge render); s_tdata carries
// the character byte and the cell address for a read. Output stream (m_*):
// exactly one transaction per input item, in order: cursor after the item,
// the byte read back, the dirty mark and a scroll flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write enable, column count and
// row count; write them only while no item is in flight.
//
// Each item passes through ST_EMIT, a read through ST_READ first, before
// m_tvalid rises; s_tready returns with m_tvalid, so a new item is taken
// only once the last result has moved to the output register. The first
// write into a row since the last clear sweeps that row. A scroll rewrites
// every active row through the cell RAM, one cell per cycle, after the row
// sweep when one comes first; the RAM has a single read and a single write
// port.
// Reset (and the clear command) marks every row blank in per-row flags, so
// no sweep of the RAM is needed. The next input is taken while a result still
// waits in the output register; a stalled receiver holds the block only once
// a second result is ready.
module text_window_char_writer import twcw_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] char_code, [12:8] read_row, [18:13] read_col, [23:19] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [4:0] cursor_row, [10:5] cursor_col, [18:11] read_char, [19] dirty,
  // [20] scrolled, [23:21] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int RW    = idx_w(MAX_ROWS);
  localparam int CW    = idx_w(MAX_COLS);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_ROWS << CW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FILL   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_READ   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state;
  logic [RW-1:0]         cursor_row;
  logic [CW-1:0]         cursor_col;
  logic                  dirty;
  logic                  window_enabled;
  logic [CNW-1:0]        cols_in_use;
  logic [RNW-1:0]        rows_in_use;
  logic [MAX_ROWS-1:0]   row_valid;     // 0: row holds only spaces
  logic [RW-1:0]         scroll_row;
  logic                  need_scroll;
  logic                  rd_row_ok;
  logic [7:0]            res_read_char;
  logic                  res_scrolled;
  logic                  emit_fire;

  // Input decode
  cmd_t                  cmd;
  logic [7:0]            ch;
  logic [4:0]            rr;
  logic [5:0]            rc;
  logic                  accept;
  logic                  write_act;
  logic                  is_lf;
  logic                  is_print;
  logic [CW:0]           col_inc;
  logic [RW:0]           row_inc;
  logic                  wrap;
  logic                  row_over;
  logic                  new_line;
  logic                  do_scroll;
  logic                  need_fill;
  logic                  direct_wr;
  logic                  read_ok;
  logic [RW-1:0]         last_row;

  // Row engine job
  logic                  eng_start;
  row_job_flags_t        eng_flags;
  logic [RW-1:0]         eng_dst;
  logic [RW-1:0]         eng_src;
  logic [CW-1:0]         eng_char_col;
  logic [7:0]            eng_char;
  logic                  scroll_go;
  logic [RW-1:0]         scroll_sel;
  row_eng_status_t       eng_status;

  // RAM ports
  logic                  eng_rd_en;
  logic [RW+CW-1:0]      eng_rd_addr;
  logic                  eng_wr_en;
  logic [RW+CW-1:0]      eng_wr_addr;
  logic [7:0]            eng_wr_data;
  logic                  top_rd_en;
  logic [RW+CW-1:0]      top_rd_addr;
  logic [RW+CW-1:0]      top_wr_addr;
  logic                  ram_rd_en;
  logic [RW+CW-1:0]      ram_rd_addr;
  logic                  ram_wr_en;
  logic [RW+CW-1:0]      ram_wr_addr;
  logic [7:0]            ram_wr_data;
  logic [7:0]            ram_rd_data;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Result moves into the output register once that register is free
  assign emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);

  assign cmd = cmd_t'(s_tuser);
  assign ch  = s_tdata[7:0];
  assign rr  = s_tdata[12:8];
  assign rc  = s_tdata[18:13];

  // Carriage return and a closed window leave everything as it is
  assign write_act = accept && cmd == CMD_WRITE && window_enabled && ch != CHAR_CR;
  assign is_lf     = (ch == CHAR_LF);
  assign is_print  = !is_lf && ((ch & LOW7_MASK) >= PRINT_MIN);

  assign col_inc  = {1'b0, cursor_col} + 1'b1;
  assign row_inc  = {1'b0, cursor_row} + 1'b1;
  assign wrap     = col_inc >= (CW+1)'(cols_in_use);
  assign row_over = row_inc >= (RW+1)'(rows_in_use);
  assign last_row = RW'(rows_in_use - 1'b1);

  assign new_line  = write_act && (is_lf || (is_print && wrap));
  assign do_scroll = new_line && row_over;
  assign need_fill = write_act && is_print && !row_valid[cursor_row];
  assign direct_wr = write_act && is_print && row_valid[cursor_row];

  assign read_ok = (int'(rr) < MAX_ROWS) && (int'(rc) < MAX_COLS);

  // Launch row sweeps: first write into a blank row, then each scrolled row
  always_comb begin
    eng_start    = 1'b0;
    eng_flags    = '0;
    eng_dst      = cursor_row;
    eng_src      = cursor_row;
    eng_char_col = cursor_col;
    eng_char     = ch;
    scroll_go    = 1'b0;
    scroll_sel   = '0;
    if (need_fill) begin
      eng_start          = 1'b1;
      eng_flags.has_char = 1'b1;
    end else if (do_scroll) begin
      scroll_go = 1'b1;
    end else if (state == ST_FILL && eng_status.done && need_scroll) begin
      scroll_go = 1'b1;
    end else if (state == ST_SCROLL && eng_status.done && scroll_row != last_row) begin
      scroll_go  = 1'b1;
      scroll_sel = scroll_row + 1'b1;
    end
    if (scroll_go) begin
      eng_start           = 1'b1;
      eng_dst             = scroll_sel;
      eng_flags.dst_valid = row_valid[scroll_sel];
      // Bottom row of the active area takes blanks
      if (scroll_sel == last_row) begin
        eng_src = scroll_sel;
      end else begin
        eng_src             = scroll_sel + 1'b1;
        eng_flags.src_valid = row_valid[eng_src];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cursor_row     <= '0;
      cursor_col     <= '0;
      dirty          <= 1'b0;
      window_enabled <= 1'b0;
      cols_in_use    <= CNW'(MAX_COLS);
      rows_in_use    <= RNW'(MAX_ROWS);
      row_valid      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (eng_start) begin
        row_valid[eng_dst] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_read_char <= '0;
            res_scrolled  <= do_scroll;
            need_scroll   <= do_scroll;
            scroll_row    <= '0;
            state         <= ST_EMIT;
            unique case (cmd)
              CMD_WRITE: begin
                if (write_act && (is_lf || is_print)) begin
                  dirty <= 1'b1;
                end
                if (new_line) begin
                  cursor_col <= '0;
                  cursor_row <= row_over ? last_row : RW'(row_inc);
                end else if (write_act && is_print) begin
                  cursor_col <= CW'(col_inc);
                end
                if (need_fill) begin
                  state <= ST_FILL;
                end else if (do_scroll) begin
                  state <= ST_SCROLL;
                end
              end
              CMD_CLEAR: begin
                row_valid  <= '0;
                cursor_row <= '0;
                cursor_col <= '0;
                dirty      <= 1'b1;
              end
              CMD_READ: begin
                rd_row_ok <= row_valid[RW'(rr)];
                if (read_ok) begin
                  state <= ST_READ;
                end
              end
              CMD_ACK: begin
                if (window_enabled) begin
                  dirty <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_FILL: begin
          if (eng_status.done) begin
            state <= need_scroll ? ST_SCROLL : ST_EMIT;
          end
        end
        ST_SCROLL: begin
          if (eng_status.done) begin
            if (scroll_row == last_row) begin
              state <= ST_EMIT;
            end else begin
              scroll_row <= scroll_sel;
            end
          end
        end
        ST_READ: begin
          // A blank row reads as spaces
          res_read_char <= rd_row_ok ? ram_rd_data : CHAR_SPACE;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold the result until the output register is free
          if (emit_fire) begin
            m_tdata  <= {3'b000, res_scrolled, dirty, res_read_char,
                         6'(cursor_col), 5'(cursor_row)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Clamp sizes to one through maximum
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ENABLE: window_enabled <= cfg_wdata[0];
          CFG_COLS: begin
            if (cfg_wdata == '0) begin
              cols_in_use <= CNW'(1);
            end else if (int'(cfg_wdata) > MAX_COLS) begin
              cols_in_use <= CNW'(MAX_COLS);
            end else begin
              cols_in_use <= CNW'(cfg_wdata);
            end
          end
          CFG_ROWS: begin
            if (cfg_wdata[5:0] == '0) begin
              rows_in_use <= RNW'(1);
            end else if (int'(cfg_wdata[5:0]) > MAX_ROWS) begin
              rows_in_use <= RNW'(MAX_ROWS);
            end else begin
              rows_in_use <= RNW'(cfg_wdata[5:0]);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Direct cell write into a row that already holds data; read command port
  assign top_wr_addr = {cursor_row, cursor_col};
  assign top_rd_en   = accept && cmd == CMD_READ && read_ok;
  assign top_rd_addr = {RW'(rr), CW'(rc)};

  assign ram_rd_en   = eng_rd_en || top_rd_en;
  assign ram_rd_addr = eng_rd_en ? eng_rd_addr : top_rd_addr;
  assign ram_wr_en   = eng_wr_en || direct_wr;
  assign ram_wr_addr = eng_wr_en ? eng_wr_addr : top_wr_addr;
  assign ram_wr_data = eng_wr_en ? eng_wr_data : ch;

  twcw_row_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_row_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (eng_start),
    .flags    (eng_flags),
    .dst_row  (eng_dst),
    .src_row  (eng_src),
    .char_col (eng_char_col),
    .char_val (eng_char),
    .cols     (cols_in_use),
    .status   (eng_status),
    .rd_en    (eng_rd_en),
    .rd_addr  (eng_rd_addr),
    .rd_data  (ram_rd_data),
    .wr_en    (eng_wr_en),
    .wr_addr  (eng_wr_addr),
    .wr_data  (eng_wr_data)
  );

  twcw_ram #(
    .WIDTH  (8),
    .DEPTH  (DEPTH),
    .ADDR_W (RW + CW)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The control side never touches the RAM while a sweep runs
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !eng_status.busy)
    else $error("input taken while row sweep busy");

  assert property (@(posedge clk) disable iff (rst)
    eng_start |-> !eng_status.active)
    else $error("row sweep launched over a running one");

  assert property (@(posedge clk) disable iff (rst)
    !(eng_status.busy && (direct_wr || top_rd_en)))
    else $error("RAM port conflict between sweep and direct access");

  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_CLEAR) |=>
      (cursor_row == '0 && cursor_col == '0 && row_valid == '0 && dirty))
    else $error("clear did not home cursor and blank rows");

endmodule
